// ===== rtl/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority queue: default sizes,
// request kind codes, sequencer states and result flags.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int SPQ_QUEUE_DEPTH = 16;
    localparam int SPQ_ID_WIDTH    = 8;
    localparam int SPQ_PRIO_WIDTH  = 8;

    // request kinds carried on the input tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_POP,
        ST_RESULT
    } t_spq_state;

    // result flags, pop_valid in bit 0
    typedef struct packed {
        logic insert_dropped;
        logic pop_valid;
    } t_spq_flags;

endpackage
`default_nettype wire

// ===== rtl/spq_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_mem
// Slot store of the queue: one write port and one read port with a
// registered read word.
// ----------------------------------------------------------------------------
module spq_mem #(
    parameter  int DEPTH = 16,
    parameter  int DW    = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the queue. The slots form a ring starting at the head
// pointer. An insert walks from the tail toward the head, one slot per
// cycle, moving each lower-priority word up by one with a single compare
// unit until it finds the place of the new job. A pop reads the head word
// and advances the head pointer.
// ----------------------------------------------------------------------------
module spq_ctrl #(
    parameter  int QUEUE_DEPTH = 16,
    parameter  int ID_WIDTH    = 8,
    localparam int AW          = $clog2(QUEUE_DEPTH),
    localparam int CW          = $clog2(QUEUE_DEPTH + 1),
    localparam int DW          = ID_WIDTH + spq_pkg::SPQ_PRIO_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request side
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_kind,
    input  wire logic [ID_WIDTH-1:0]                i_job_id,
    input  wire logic [spq_pkg::SPQ_PRIO_WIDTH-1:0] i_priority_req,
    // slot store
    output logic                                    o_we,
    output logic      [AW-1:0]                      o_waddr,
    output logic      [DW-1:0]                      o_wdata,
    output logic      [AW-1:0]                      o_raddr,
    input  wire logic [DW-1:0]                      i_rdata,
    // result side
    output logic                                    o_res_valid,
    input  wire logic                               i_res_take,
    output spq_pkg::t_spq_flags                     o_flags,
    output logic      [ID_WIDTH-1:0]                o_job_out,
    output logic      [spq_pkg::SPQ_PRIO_WIDTH-1:0] o_priority_out,
    output logic      [CW-1:0]                      o_occupancy
);

    import spq_pkg::*;

    localparam int            PW        = SPQ_PRIO_WIDTH;
    localparam logic [CW:0]   DEPTH_EXT = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

    t_spq_state    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_k, n_k;
    logic [ID_WIDTH-1:0] r_id, n_id;
    logic [PW-1:0] r_prio, n_prio;
    t_spq_flags    r_flags, n_flags;
    logic [ID_WIDTH-1:0] r_job_out, n_job_out;
    logic [PW-1:0] r_prio_out, n_prio_out;

    logic          in_fire;
    logic          place;
    logic [PW-1:0] rd_prio;
    logic [CW-1:0] rd_j;

    // ring position of the j-th queued job, j below QUEUE_DEPTH
    function automatic logic [AW-1:0] slot_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] j);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(j);
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[AW-1:0];
    endfunction

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign rd_prio    = i_rdata[DW-1:ID_WIDTH];
    // the new job goes here once the word below it ranks equal or higher
    assign place      = (r_k == '0) || (rd_prio >= r_prio);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_kind == KIND_POP) begin
                        n_state = (r_count == '0) ? ST_RESULT : ST_POP;
                    end else begin
                        n_state = (r_count == DEPTH_CNT) ? ST_RESULT : ST_INS;
                    end
                end
            end
            ST_INS: begin
                if (place) begin
                    n_state = ST_RESULT;
                end
            end
            ST_POP: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_k        = r_k;
        n_id       = r_id;
        n_prio     = r_prio;
        n_flags    = r_flags;
        n_job_out  = r_job_out;
        n_prio_out = r_prio_out;
        o_we       = 1'b0;
        o_wdata    = {r_prio, r_id};
        rd_j       = '0;
        unique case (r_state)
            ST_IDLE: begin
                // prefetch the tail for an insert, the head for a pop
                if (i_kind == KIND_INSERT && r_count != '0) begin
                    rd_j = r_count - 1'b1;
                end
                if (in_fire) begin
                    n_id                   = i_job_id;
                    n_prio                 = i_priority_req;
                    n_k                    = r_count;
                    n_job_out              = '0;
                    n_prio_out             = '0;
                    n_flags.pop_valid      = 1'b0;
                    n_flags.insert_dropped = (i_kind == KIND_INSERT) &&
                                             (r_count == DEPTH_CNT);
                end
            end
            ST_INS: begin
                o_we = 1'b1;
                if (r_k >= CW'(2)) begin
                    rd_j = r_k - CW'(2);
                end
                if (place) begin
                    n_count = r_count + 1'b1;
                end else begin
                    // move the lower-priority word one slot toward the tail
                    o_wdata = i_rdata;
                    n_k     = r_k - 1'b1;
                end
            end
            ST_POP: begin
                n_job_out         = i_rdata[ID_WIDTH-1:0];
                n_prio_out        = rd_prio;
                n_flags.pop_valid = 1'b1;
                n_head            = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                n_count           = r_count - 1'b1;
            end
            ST_RESULT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_waddr = slot_addr(r_head, r_k);
    assign o_raddr = slot_addr(r_head, rd_j);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_id       <= n_id;
        r_prio     <= n_prio;
        r_flags    <= n_flags;
        r_job_out  <= n_job_out;
        r_prio_out <= n_prio_out;
    end

    assign o_res_valid    = (r_state == ST_RESULT);
    assign o_flags        = r_flags;
    assign o_job_out      = r_job_out;
    assign o_priority_out = r_prio_out;
    assign o_occupancy    = r_count;

endmodule
`default_nettype wire

// ===== rtl/stable_priority_queue_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Bounded priority queue of jobs; equal priorities leave first in, first out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser is the request kind (insert or pop), tdata carries
//   job_id and priority_req. Each word yields exactly one master word with
//   job_out, priority_out and occupancy in tdata and the pop_valid and
//   insert_dropped flags in tuser.
//   Sequencing: the block takes one word at a time. A pop reads the head
//   slot and registers it as the result; a rejected insert or an empty pop
//   goes straight to the result. An insert first walks past each stored job
//   that ranks below the new one (at most QUEUE_DEPTH - 1 of them). The next
//   word is taken in the cycle after the result enters the output register.
//   The insert walk moves one slot per cycle through the single write port
//   of the store. The result sits in an output register, so the next request
//   may be accepted while it waits; a further result holds inside the
//   sequencer until that register drains.
//   Reset empties the queue at once (head pointer and count clear); the slot
//   store itself is not cleared. A stalled receiver holds the output word.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
    parameter  int QUEUE_DEPTH = spq_pkg::SPQ_QUEUE_DEPTH,
    parameter  int ID_WIDTH    = spq_pkg::SPQ_ID_WIDTH,
    localparam int CW          = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W        = ((ID_WIDTH + spq_pkg::SPQ_PRIO_WIDTH + 7) / 8) * 8,
    localparam int OUT_W       = ((ID_WIDTH + spq_pkg::SPQ_PRIO_WIDTH + CW + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // slave stream
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [IN_W-1:0]  i_s_axis_tdata,  // job_id, priority_req, zero pad
    input  wire logic [0:0]       i_s_axis_tuser,  // kind
    // master stream
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic      [OUT_W-1:0] o_m_axis_tdata,  // job_out, priority_out, occupancy, zero pad
    output spq_pkg::t_spq_flags   o_m_axis_tuser   // pop_valid, insert_dropped
);

    import spq_pkg::*;

    localparam int PW = SPQ_PRIO_WIDTH;
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int DW = ID_WIDTH + PW;

    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [DW-1:0] rdata;

    logic                res_valid;
    logic                res_take;
    t_spq_flags          res_flags;
    logic [ID_WIDTH-1:0] res_job;
    logic [PW-1:0]       res_prio;
    logic [CW-1:0]       res_occ;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    t_spq_flags       r_out_flags;

    spq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_s_axis_tvalid),
        .o_in_ready     (o_s_axis_tready),
        .i_kind         (i_s_axis_tuser[0]),
        .i_job_id       (i_s_axis_tdata[ID_WIDTH-1:0]),
        .i_priority_req (i_s_axis_tdata[DW-1:ID_WIDTH]),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_res_valid    (res_valid),
        .i_res_take     (res_take),
        .o_flags        (res_flags),
        .o_job_out      (res_job),
        .o_priority_out (res_prio),
        .o_occupancy    (res_occ)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data  <= OUT_W'({res_occ, res_prio, res_job});
            r_out_flags <= res_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flags;

endmodule
`default_nettype wire
